FILE: hdl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, constants and command/status bundles of the region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned MAX_REGIONS = 64;
  localparam int unsigned AW          = $clog2(MAX_REGIONS);
  localparam int unsigned IDX_W       = $clog2(MAX_REGIONS + 1);
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAPPING_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] request_length;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_address;
    logic [1:0]        status;
    logic              removed;
    logic [IDX_W-1:0]  region_count;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] length;
  } entry_t;

  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_COUNT, IDX_INC, IDX_DEC} idx_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_e;
  typedef enum logic [1:0] {POS_HOLD, POS_HIT, POS_TAIL, POS_EMPTY} pos_op_e;
  typedef enum logic [1:0] {RD_CUR, RD_PREV, RD_NEXT} rd_sel_e;
  typedef enum logic {WR_SHIFT, WR_NEW} wr_sel_e;

  typedef struct packed {
    logic       load_item;
    idx_op_e    idx_op;
    cnt_op_e    cnt_op;
    pos_op_e    pos_op;
    logic       prev_load;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    wr_sel_e    wr_sel;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_removed;
    logic       res_alloc;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       count_full;
    logic       misaligned;
    logic       idx_zero;
    logic       idx_last;
    logic       idx_at_pos;
    logic       gap_fit;
    logic       match;
    logic       too_long;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: hdl/ffra_datapath.sv
// ----------------------------------------------------------------------------
// ffra_datapath
// Region table memory, index and count registers, config and result registers.
// ----------------------------------------------------------------------------
module ffra_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffra_pkg::in_item_t              in_item_i,
  input  logic                            cfg_valid_i,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffra_pkg::ADDR_W-1:0]     cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output ffra_pkg::out_item_t             out_item_o,
  input  ffra_pkg::dp_cmd_t               cmd_i,
  output ffra_pkg::dp_sts_t               sts_o
);
  import ffra_pkg::*;

  entry_t              mem_q [MAX_REGIONS];
  entry_t              rdata_q;
  in_item_t            item_q;
  logic [ADDR_W-1:0]   base_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [IDX_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    pos_q;
  logic [ADDR_W-1:0]   prev_end_q;
  logic [ADDR_W-1:0]   s_q;
  logic [ADDR_W-1:0]   res_start_q;
  logic [1:0]          res_status_q;
  logic                res_removed_q;
  out_item_t           out_q;
  logic                out_valid_q, out_valid_d;

  logic [ADDR_W-1:0]   page_mask;
  logic [ADDR_W-1:0]   end_sum;
  logic [ADDR_W-1:0]   end_round;
  logic [ADDR_W-1:0]   gap;
  logic [IDX_W-1:0]    raddr_full;
  logic [IDX_W-1:0]    waddr_full;
  entry_t              wdata;

  assign page_mask = (ADDR_W'(1) << shift_q) - ADDR_W'(1);
  assign end_sum   = s_q + item_q.request_length;
  assign end_round = (end_sum + page_mask) & ~page_mask;
  assign gap       = rdata_q.start_addr - prev_end_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PREV: raddr_full = idx_q - IDX_W'(1);
      RD_NEXT: raddr_full = idx_q + IDX_W'(1);
      default: raddr_full = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_NEW: begin
        waddr_full       = pos_q;
        wdata.start_addr = s_q;
        wdata.end_addr   = end_round;
        wdata.length     = item_q.request_length;
      end
      default: begin
        waddr_full = idx_q;
        wdata      = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_full[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_full[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_ZERO:  idx_d = '0;
      IDX_COUNT: idx_d = count_q;
      IDX_INC:   idx_d = idx_q + IDX_W'(1);
      IDX_DEC:   idx_d = idx_q - IDX_W'(1);
      default:   idx_d = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + IDX_W'(1);
      CNT_DEC: count_d = count_q - IDX_W'(1);
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      shift_q     <= SHIFT_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MAPPING_BASE: base_q  <= cfg_data_i;
          REG_PAGE_SHIFT:   shift_q <= cfg_data_i[SHIFT_W-1:0];
          default:          base_q  <= base_q;
        endcase
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    idx_q <= idx_d;
    if (cmd_i.prev_load) begin
      prev_end_q <= rdata_q.end_addr;
    end
    unique case (cmd_i.pos_op)
      POS_HIT: begin
        pos_q <= idx_q;
        s_q   <= prev_end_q;
      end
      POS_TAIL: begin
        pos_q <= count_q;
        s_q   <= rdata_q.end_addr;
      end
      POS_EMPTY: begin
        pos_q <= '0;
        s_q   <= base_q;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
    if (cmd_i.res_load) begin
      res_start_q   <= cmd_i.res_alloc ? s_q : '0;
      res_status_q  <= cmd_i.res_status;
      res_removed_q <= cmd_i.res_removed;
    end
    if (cmd_i.out_load) begin
      out_q.start_address <= res_start_q;
      out_q.status        <= res_status_q;
      out_q.removed       <= res_removed_q;
      out_q.region_count  <= count_q;
    end
  end

  assign sts_o.op         = item_q.operation;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == IDX_W'(MAX_REGIONS));
  assign sts_o.misaligned = ((item_q.address & page_mask) != '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_last   = (idx_q == (count_q - IDX_W'(1)));
  assign sts_o.idx_at_pos = (idx_q == pos_q);
  assign sts_o.gap_fit    = (gap >= item_q.request_length);
  assign sts_o.match      = (rdata_q.start_addr == item_q.address);
  assign sts_o.too_long   = (rdata_q.length < item_q.request_length);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hdl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer for allocate scan/insert, free search/remove, clear and reply.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffra_pkg::dp_sts_t   sts_i,
  output ffra_pkg::dp_cmd_t   cmd_o
);
  import ffra_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_UP_RD    = 4'd4;
  localparam logic [3:0] S_UP_WR    = 4'd5;
  localparam logic [3:0] S_WR_NEW   = 4'd6;
  localparam logic [3:0] S_FR_RD    = 4'd7;
  localparam logic [3:0] S_FR_CHK   = 4'd8;
  localparam logic [3:0] S_DN_RD    = 4'd9;
  localparam logic [3:0] S_DN_WR    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.op == OP_ALLOC) begin
          if (sts_i.count_full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_DONE;
          end else if (sts_i.count_zero) begin
            cmd_o.pos_op = POS_EMPTY;
            state_d      = S_WR_NEW;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_SCAN_RD;
          end
        end else if (sts_i.op == OP_FREE) begin
          if (sts_i.misaligned) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_MISALIGN;
            state_d          = S_DONE;
          end else if (sts_i.count_zero) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_FR_RD;
          end
        end else if (sts_i.op == OP_CLEAR) begin
          cmd_o.cnt_op   = CNT_CLR;
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (sts_i.gap_fit && !sts_i.idx_zero) begin
          cmd_o.pos_op = POS_HIT;
          cmd_o.idx_op = IDX_COUNT;
          state_d      = S_UP_RD;
        end else if (sts_i.idx_last) begin
          cmd_o.pos_op = POS_TAIL;
          cmd_o.idx_op = IDX_COUNT;
          state_d      = S_UP_RD;
        end else begin
          cmd_o.prev_load = 1'b1;
          cmd_o.idx_op    = IDX_INC;
          state_d         = S_SCAN_RD;
        end
      end
      S_UP_RD: begin
        if (sts_i.idx_at_pos) begin
          state_d = S_WR_NEW;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_UP_RD;
      end
      S_WR_NEW: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_NEW;
        cmd_o.cnt_op    = CNT_INC;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_alloc = 1'b1;
        state_d         = S_DONE;
      end
      S_FR_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_FR_CHK;
      end
      S_FR_CHK: begin
        priority if (sts_i.match) begin
          if (sts_i.too_long) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_TOO_LONG;
            state_d          = S_DONE;
          end else begin
            state_d = S_DN_RD;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_FR_RD;
        end
      end
      S_DN_RD: begin
        if (sts_i.idx_last) begin
          cmd_o.cnt_op      = CNT_DEC;
          cmd_o.res_load    = 1'b1;
          cmd_o.res_removed = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DN_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/first_fit_region_allocator.sv
// Clear, unused ops and rejected items go from decode straight to the reply state.
// Allocate scans entries for the first fitting gap, moves later entries up one slot and
// writes the new entry (only the write when empty). Free searches for the matching entry
// and moves later entries down one slot. One item at a time: the input stalls until the
// result is loaded into the output register. Reset: base 0, page shift 12, table empty.
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit address range allocator: controller plus table datapath.
// ----------------------------------------------------------------------------
module first_fit_region_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ffra_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ffra_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffra_pkg::ADDR_W-1:0]     cfg_data_i
);
  import ffra_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffra_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: hdl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  ffra_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  ffra_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffra_pkg::ADDR_W-1:0]     cfg_data_i
);
  import ffra_pkg::*;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.region_count <= IDX_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |-> out_item_o.start_address == '0)
    else $error("nonzero start on failed transaction");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.removed) |-> out_item_o.status == ST_OK)
    else $error("removed flagged with error status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("new transaction taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit region allocator against a cycle-free table model.
// Directed items cover the corners; random traffic then builds and frees
// regions under three idle/stall profiles and several base/page settings.
// ----------------------------------------------------------------------------
module testbench;
  import ffra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_ITEMS   = 310;
  localparam logic [1:0] OP_NOP = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  first_fit_region_allocator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // allocator table model
  logic [ADDR_W-1:0]  base_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [ADDR_W-1:0]  tbl_start [MAX_REGIONS];
  logic [ADDR_W-1:0]  tbl_end   [MAX_REGIONS];
  logic [ADDR_W-1:0]  tbl_len   [MAX_REGIONS];
  int                 tbl_count;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        mismatches;
  int        quiet_cycles;
  int        n_results, n_removed, n_misalign, n_too_long, n_full;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [ADDR_W-1:0] page_mask();
    return (48'd1 << shift_q) - 48'd1;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t         r;
    int                pos;
    int                i;
    int                hit;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    r = '0;
    case (it.operation)
      OP_ALLOC: begin
        if (tbl_count >= MAX_REGIONS) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_count == 0) begin
            pos = 0;
            s = base_q;
          end else begin
            pos = tbl_count;
            for (i = 0; i + 1 < tbl_count; i++) begin
              if (ADDR_W'(tbl_start[i+1] - tbl_end[i]) >= it.request_length) begin
                pos = i + 1;
                break;
              end
            end
            s = tbl_end[pos-1];
            for (i = tbl_count; i > pos; i--) begin
              tbl_start[i] = tbl_start[i-1];
              tbl_end[i]   = tbl_end[i-1];
              tbl_len[i]   = tbl_len[i-1];
            end
          end
          e = s + it.request_length;
          e = e + page_mask();
          tbl_start[pos] = s;
          tbl_len[pos]   = it.request_length;
          tbl_end[pos]   = e & ~page_mask();
          tbl_count++;
          r.start_address = s;
        end
      end
      OP_FREE: begin
        if ((it.address & page_mask()) != '0) begin
          r.status = ST_MISALIGN;
        end else begin
          hit = -1;
          for (i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_start[i] == it.address) hit = i;
          end
          if (hit >= 0) begin
            if (tbl_len[hit] < it.request_length) begin
              r.status = ST_TOO_LONG;
            end else begin
              for (i = hit; i + 1 < tbl_count; i++) begin
                tbl_start[i] = tbl_start[i+1];
                tbl_end[i]   = tbl_end[i+1];
                tbl_len[i]   = tbl_len[i+1];
              end
              tbl_count--;
              r.removed = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.region_count = IDX_W'(tbl_count);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       k;
    it.operation      = OP_ALLOC;
    it.address        = rand_addr();
    it.request_length = rand_addr();
    pick = $urandom_range(0, 99);
    if (pick < 56) begin
      k = $urandom_range(0, 9);
      if (k < 7) it.request_length &= (48'd1 << (int'(shift_q) + 2)) - 48'd1;
      else if (k == 7) it.request_length = '0;
    end else if (pick < 96) begin
      it.operation = OP_FREE;
      if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, tbl_count - 1);
        it.address = tbl_start[k];
        case ($urandom_range(0, 5))
          0:       it.request_length = tbl_len[k] + 48'd1;
          1:       ;
          2:       it.request_length = '0;
          default: it.request_length = (tbl_len[k] > 48'd3) ?
                                       tbl_len[k] - ADDR_W'($urandom_range(0, 3)) :
                                       tbl_len[k];
        endcase
      end else if ($urandom_range(0, 1) == 0) begin
        it.address &= ~page_mask();
      end
    end else if (pick < 99) begin
      it.operation = OP_NOP;
    end else begin
      it.operation = OP_CLEAR;
    end
    return it;
  endfunction

  task automatic push_item(logic [1:0] op, logic [ADDR_W-1:0] len, logic [ADDR_W-1:0] addr);
    in_item_t it;
    it.operation      = op;
    it.request_length = len;
    it.address        = addr;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAPPING_BASE) base_q = data;
    else shift_q = data[SHIFT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver
  logic in_took;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_item_t exp_r;
    logic      active;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      active  = in_took || (cfg_valid && cfg_ready);
      if (in_took) expected_results.push_back(apply_item(in_item));
      if (out_valid && !out_stall) begin
        active = 1'b1;
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: start %h/%h status %0d/%0d removed %0d/%0d count %0d/%0d",
                       exp_r.start_address, out_item.start_address, exp_r.status,
                       out_item.status, exp_r.removed, out_item.removed,
                       exp_r.region_count, out_item.region_count);
          end
          if (exp_r.removed) n_removed++;
          case (exp_r.status)
            ST_MISALIGN: n_misalign++;
            ST_TOO_LONG: n_too_long++;
            ST_FULL:     n_full++;
            default: ;
          endcase
        end
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] b;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAPPING_BASE;
    cfg_data  = '0;
    in_took   = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 71;
    mismatches = 0;
    quiet_cycles = 0;
    n_results = 0; n_removed = 0; n_misalign = 0; n_too_long = 0; n_full = 0;
    base_q    = '0;
    shift_q   = SHIFT_RESET;
    tbl_count = 0;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    b = 48'h0000_0001_0000;
    write_reg(REG_MAPPING_BASE, b);
    write_reg(REG_PAGE_SHIFT, 48'd12);
    push_item(OP_FREE, 48'd0, 48'd1);
    push_item(OP_FREE, 48'd0, 48'h5000);
    push_item(OP_NOP, '1, '1);
    push_item(OP_ALLOC, 48'd0, '0);
    push_item(OP_ALLOC, 48'd1, '0);
    push_item(OP_ALLOC, 48'h1000, '0);
    push_item(OP_ALLOC, 48'h1001, '0);
    push_item(OP_FREE, 48'h1000, b + 48'h1000);
    push_item(OP_ALLOC, 48'h800, '0);
    push_item(OP_FREE, 48'h2000, b + 48'h2000);
    push_item(OP_FREE, '1, b + 48'h2000);
    push_item(OP_ALLOC, '1, '0);
    push_item(OP_ALLOC, 48'd5, '1);
    push_item(OP_FREE, 48'd0, 48'hFFFF_FFFF_F000);
    push_item(OP_FREE, 48'd0, b);
    push_item(OP_CLEAR, '1, '1);
    push_item(OP_ALLOC, 48'h3, '0);
    push_item(OP_CLEAR, '0, '0);

    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0: begin
          send_idle_pct = 13; recv_idle_pct = 71;
          write_reg(REG_MAPPING_BASE, '1);
          write_reg(REG_PAGE_SHIFT, 48'd12);
        end
        1: begin
          send_idle_pct = 71; recv_idle_pct = 13;
          write_reg(REG_MAPPING_BASE, rand_addr());
          write_reg(REG_PAGE_SHIFT, 48'd0);
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_reg(REG_MAPPING_BASE, '0);
          write_reg(REG_PAGE_SHIFT, 48'd30);
        end
      endcase
      push_item(OP_CLEAR, '0, '0);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        while (pending_items.size() >= 2) @(posedge clk);
        pending_items.push_back(random_item());
      end
    end
    drain();

    $display("covered %0d transactions: %0d regions freed, %0d misaligned, %0d too long, %0d full",
             n_results, n_removed, n_misalign, n_too_long, n_full);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
